@@ design/vector_l2_normalize_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the vector L2 normalizer
// Shared concurrent assertion forms used by the controller and the datapath.
// ----------------------------------------------------------------------------
`ifndef VECTOR_L2_NORMALIZE_ASSERT_SVH
`define VECTOR_L2_NORMALIZE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VL2N_ASSERT_IMPL(name, clock, reset, ante, cons, msg) \
  name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VL2N_ASSERT_NEXT(name, clock, reset, ante, cons, msg) \
  name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);

// The condition must never be true.
`define VL2N_ASSERT_NEVER(name, clock, reset, cond, msg) \
  name: assert property (@(posedge clock) disable iff (reset) !(cond)) \
    else $error(msg);

`endif

@@ design/vl2n_pkg.sv @@
// ----------------------------------------------------------------------------
// Vector L2 normalizer package
// Widths, constants and the command and status bundles shared by the modules.
// ----------------------------------------------------------------------------
package vl2n_pkg;

  localparam int MAX_LENGTH_DEF = 64;
  localparam int DATA_W         = 16;
  localparam int FRAC_W         = 15;
  localparam int QUOT_W         = 16;
  // One square of a 16-bit magnitude is at most 2^30.
  localparam int SQ_W           = 31;
  localparam int SUM_W_DEF      = SQ_W + $clog2(MAX_LENGTH_DEF);
  localparam int ROOT_W_DEF     = (SUM_W_DEF + 1) / 2;

  localparam logic [DATA_W-1:0] Q15_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;        // input transfer this cycle
    logic sqrt_start;  // load the sum into the root unit
    logic rd_en;       // read the current store entry
    logic div_start;   // start dividing the entry read last cycle
    logic out_load;    // load the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sqrt_done;
    logic div_done;
    logic out_free;
    logic emit_last;
  } stat_t;

endpackage

@@ design/vl2n_isqrt.sv @@
// ----------------------------------------------------------------------------
// Iterative integer square root
// Digit-by-digit restoring root, one result bit per cycle.
// ----------------------------------------------------------------------------
module vl2n_isqrt #(
  parameter int SUM_W  = vl2n_pkg::SUM_W_DEF,
  parameter int ROOT_W = vl2n_pkg::ROOT_W_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SUM_W-1:0]  radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);
  import vl2n_pkg::*;

  localparam int RAD_W = 2 * ROOT_W;
  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic [RAD_W-1:0]  rad;
  logic [ROOT_W+1:0] rem;
  logic [CNT_W-1:0]  steps;
  logic              busy;

  logic [ROOT_W+1:0] rem_sh;
  logic [ROOT_W+1:0] trial;
  logic              ge;

  assign rem_sh = {rem[ROOT_W-1:0], rad[RAD_W-1 -: 2]};
  assign trial  = {root, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= CNT_W'(ROOT_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= RAD_W'(radicand);
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= rad << 2;
      rem  <= ge ? (rem_sh - trial) : rem_sh;
      root <= {root[ROOT_W-2:0], ge};
    end
  end

endmodule

@@ design/vl2n_div.sv @@
// ----------------------------------------------------------------------------
// Iterative Q1.15 divider
// Restoring division of magnitude * 2^15 by the root, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module vl2n_div #(
  parameter int ROOT_W = vl2n_pkg::ROOT_W_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [vl2n_pkg::DATA_W-1:0] absval,
  input  logic [ROOT_W-1:0]           divisor,
  output logic                        done,
  output logic [vl2n_pkg::QUOT_W-1:0] quot
);
  import vl2n_pkg::*;

  localparam int CNT_W = $clog2(QUOT_W + 1);

  // The quotient never exceeds 2^15 because the magnitude is at most the
  // root, so the remainder can start from the upper dividend bits.
  logic [ROOT_W:0]     rem;
  logic [QUOT_W-1:0]   low;
  logic [CNT_W-1:0]    steps;
  logic                busy;

  logic [ROOT_W:0]     rem_sh;
  logic [ROOT_W:0]     dvs;
  logic                ge;

  assign rem_sh = {rem[ROOT_W-1:0], low[QUOT_W-1]};
  assign dvs    = {1'b0, divisor};
  assign ge     = rem_sh >= dvs;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= CNT_W'(QUOT_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= (ROOT_W+1)'(absval[DATA_W-1:1]);
      low  <= {absval[0], {FRAC_W{1'b0}}};
      quot <= '0;
    end else if (busy) begin
      rem  <= ge ? (rem_sh - dvs) : rem_sh;
      low  <= low << 1;
      quot <= {quot[QUOT_W-2:0], ge};
    end
  end

endmodule

@@ design/vl2n_dp.sv @@
// ----------------------------------------------------------------------------
// Vector L2 normalizer datapath
// Element store, sum of squares, root and divider units, output register.
// ----------------------------------------------------------------------------
`include "vector_l2_normalize_assert.svh"

module vl2n_dp #(
  parameter int MAX_LENGTH = vl2n_pkg::MAX_LENGTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  vl2n_pkg::cmd_t                     cmd,
  output vl2n_pkg::stat_t                    stat,
  input  logic signed [vl2n_pkg::DATA_W-1:0] element,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic signed [vl2n_pkg::DATA_W-1:0] normalized,
  output logic                               last_result,
  output logic                               zero_magnitude
);
  import vl2n_pkg::*;

  localparam int CNT_W  = $clog2(MAX_LENGTH + 1);
  localparam int ADDR_W = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int SUM_W  = SQ_W + $clog2(MAX_LENGTH);
  localparam int ROOT_W = (SUM_W + 1) / 2;

  logic [DATA_W-1:0]   mem [MAX_LENGTH];
  logic [CNT_W-1:0]    cnt;
  logic [SUM_W-1:0]    sum;
  logic [SQ_W-1:0]     sq;
  logic                sq_pend;
  logic [ADDR_W-1:0]   idx;
  logic [DATA_W-1:0]   rd_data;
  logic                neg;
  logic                zmag;

  logic [DATA_W-1:0]   elem_u;
  logic [DATA_W-1:0]   mag;
  logic [2*DATA_W-1:0] prod;
  logic                store_ok;
  logic                vec_end;
  logic [DATA_W-1:0]   rd_abs;
  logic [ROOT_W-1:0]   root;
  logic [QUOT_W-1:0]   quot;
  logic [DATA_W-1:0]   norm_next;
  logic [DATA_W-1:0]   pos_val;
  logic [DATA_W-1:0]   neg_val;

  assign elem_u   = element;
  assign mag      = elem_u[DATA_W-1] ? (~elem_u + 1'b1) : elem_u;
  assign prod     = mag * mag;
  assign store_ok = cnt < CNT_W'(MAX_LENGTH);
  assign vec_end  = cmd.out_load && stat.emit_last;
  assign rd_abs   = rd_data[DATA_W-1] ? (~rd_data + 1'b1) : rd_data;

  assign stat.out_free  = !out_valid || out_ready;
  assign stat.emit_last = (CNT_W'(idx) + CNT_W'(1)) == cnt;

  // Element store: written in arrival order, read back during the emit.
  always_ff @(posedge clk) begin
    if (cmd.take && store_ok) begin
      mem[cnt[ADDR_W-1:0]] <= elem_u;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[idx];
    end
  end

  // The square is registered before it joins the running sum.
  always_ff @(posedge clk) begin
    sq <= prod[SQ_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      sum     <= '0;
      sq_pend <= 1'b0;
      idx     <= '0;
    end else begin
      sq_pend <= cmd.take && store_ok;
      if (vec_end) begin
        cnt <= '0;
        sum <= '0;
        idx <= '0;
      end else begin
        if (cmd.take && store_ok) begin
          cnt <= cnt + 1'b1;
        end
        if (sq_pend) begin
          sum <= sum + SUM_W'(sq);
        end
        if (cmd.out_load) begin
          idx <= idx + 1'b1;
        end
      end
    end
  end

  vl2n_isqrt #(
    .SUM_W  (SUM_W),
    .ROOT_W (ROOT_W)
  ) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.sqrt_start),
    .radicand (sum),
    .done     (stat.sqrt_done),
    .root     (root)
  );

  vl2n_div #(
    .ROOT_W (ROOT_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.div_start),
    .absval  (rd_abs),
    .divisor (root),
    .done    (stat.div_done),
    .quot    (quot)
  );

  always_ff @(posedge clk) begin
    if (stat.sqrt_done) begin
      zmag <= (root == '0);
    end
    if (cmd.div_start) begin
      neg <= rd_data[DATA_W-1];
    end
  end

  // A quotient of exactly one saturates on the positive side only.
  assign pos_val   = quot[QUOT_W-1] ? Q15_MAX : quot;
  assign neg_val   = ~quot + 1'b1;
  assign norm_next = zmag ? '0 : (neg ? neg_val : pos_val);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      normalized     <= norm_next;
      last_result    <= stat.emit_last;
      zero_magnitude <= zmag;
    end
  end

  `VL2N_ASSERT_NEVER(a_cnt_range, clk, rst, cnt > CNT_W'(MAX_LENGTH), "element count overflow")
  `VL2N_ASSERT_NEXT(a_vec_clear, clk, rst, vec_end, (cnt == '0) && (sum == '0), "vector state not cleared")
  `VL2N_ASSERT_IMPL(a_zero_out, clk, rst, out_valid && zero_magnitude, normalized == '0, "nonzero result on zero magnitude")

endmodule

@@ design/vl2n_ctrl.sv @@
// ----------------------------------------------------------------------------
// Vector L2 normalizer controller
// Sequences the load, root, per-element division and output steps.
// ----------------------------------------------------------------------------
`include "vector_l2_normalize_assert.svh"

module vl2n_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            last_element,
  output logic            in_ready,
  output vl2n_pkg::cmd_t  cmd,
  input  vl2n_pkg::stat_t stat
);
  import vl2n_pkg::*;

  localparam logic [2:0] S_LOAD      = 3'd0;
  localparam logic [2:0] S_SUM       = 3'd1;
  localparam logic [2:0] S_SQ_START  = 3'd2;
  localparam logic [2:0] S_SQ_RUN    = 3'd3;
  localparam logic [2:0] S_READ      = 3'd4;
  localparam logic [2:0] S_DIV_START = 3'd5;
  localparam logic [2:0] S_DIV_RUN   = 3'd6;
  localparam logic [2:0] S_PUT       = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready       = (state == S_LOAD);
  assign cmd.take       = in_valid && in_ready;
  assign cmd.sqrt_start = (state == S_SQ_START);
  assign cmd.rd_en      = (state == S_READ);
  assign cmd.div_start  = (state == S_DIV_START);
  assign cmd.out_load   = (state == S_PUT) && stat.out_free;

  always_comb begin
    state_next = state;
    case (state)
      S_LOAD: begin
        if (cmd.take && last_element) begin
          state_next = S_SUM;
        end
      end
      S_SUM:       state_next = S_SQ_START;
      S_SQ_START:  state_next = S_SQ_RUN;
      S_SQ_RUN: begin
        if (stat.sqrt_done) begin
          state_next = S_READ;
        end
      end
      S_READ:      state_next = S_DIV_START;
      S_DIV_START: state_next = S_DIV_RUN;
      S_DIV_RUN: begin
        if (stat.div_done) begin
          state_next = S_PUT;
        end
      end
      S_PUT: begin
        if (stat.out_free) begin
          state_next = stat.emit_last ? S_LOAD : S_READ;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  `VL2N_ASSERT_IMPL(a_sqrt_sync, clk, rst, stat.sqrt_done, state == S_SQ_RUN, "root finished outside its wait")
  `VL2N_ASSERT_IMPL(a_div_sync, clk, rst, stat.div_done, state == S_DIV_RUN, "division finished outside its wait")
  `VL2N_ASSERT_NEXT(a_last_in, clk, rst, cmd.take && last_element, !in_ready, "input taken after last element")

endmodule

@@ design/vector_l2_normalize.sv @@
// ----------------------------------------------------------------------------
// Vector L2 normalizer
// Divides each element of a Q1.15 vector by the vector's integer L2 magnitude.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake               Payload
//  -------  ----------------------  ------------------------------------------
//  input    in_valid / in_ready     element, last_element
//  output   out_valid / out_ready   normalized, last_result, zero_magnitude
//
//  While a vector is loading, one element transfer can be taken every cycle.
//  After the last element, the square root unit finds the magnitude
//  in ROOT_W root steps (19 at the default length). Each result is
//  then formed in turn by the 16-step divider.
//  Reset (rst, synchronous) clears the count, the sum and the controller.
//  A stalled output transfer holds the emit, and input stays closed until
//  the last result of the vector has been loaded into the output register.
//
module vector_l2_normalize #(
  parameter int MAX_LENGTH = vl2n_pkg::MAX_LENGTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [vl2n_pkg::DATA_W-1:0] element,
  input  logic                               last_element,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [vl2n_pkg::DATA_W-1:0] normalized,
  output logic                               last_result,
  output logic                               zero_magnitude
);
  import vl2n_pkg::*;

  // The controller and datapath talk only through these two bundles.
  cmd_t  cmd;
  stat_t stat;

  // The controller owns the input handshake and steps through the load,
  // the root, and one read, divide and output step per stored element.
  vl2n_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .last_element (last_element),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .stat         (stat)
  );

  // The datapath holds the store, the sum of squares, both iterative units
  // and the output register that parts the output side from the work.
  // Elements past the store capacity are dropped; a dropped last element
  // still starts the emit of what was stored.
  vl2n_dp #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .element        (element),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .normalized     (normalized),
    .last_result    (last_result),
    .zero_magnitude (zero_magnitude)
  );

endmodule

@@ test/vl2n_result_checker.sv @@
// ----------------------------------------------------------------------------
// Result checker for the vector L2 normalizer
// Watches both channels, predicts every normalized element from the accepted
// input transfers, and compares each output transfer field by field.
// ----------------------------------------------------------------------------
module vl2n_result_checker #(
  parameter int MAX_LEN = vl2n_pkg::MAX_LENGTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic signed [vl2n_pkg::DATA_W-1:0] element,
  input  logic                               last_element,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic signed [vl2n_pkg::DATA_W-1:0] normalized,
  input  logic                               last_result,
  input  logic                               zero_magnitude,
  output int                                 fail_count,
  output int                                 pending,
  output int                                 results_seen
);

  localparam int DW = vl2n_pkg::DATA_W;

  typedef struct packed {
    logic signed [DW-1:0] value;
    logic                 last;
    logic                 zero;
  } quotient_t;

  logic signed [DW-1:0] vector_elems[$];
  logic [36:0]          square_total = '0;
  quotient_t            expected_quotients[$];
  int                   errors = 0;
  int                   checked = 0;

  // Largest r with r * r <= s, found one root bit at a time.
  function automatic logic [18:0] floor_root(input logic [36:0] s);
    logic [18:0] r;
    logic [63:0] trial;
    r = '0;
    for (int b = 18; b >= 0; b--) begin
      trial = {45'd0, r | (19'd1 << b)};
      if (trial * trial <= {27'd0, s}) r = trial[18:0];
    end
    return r;
  endfunction

  // Element scaled by 2^15 over the magnitude, truncated toward zero and
  // clamped to the Q1.15 range.
  function automatic logic signed [DW-1:0] scaled_quotient(
    input logic signed [DW-1:0] e, input logic [18:0] m);
    int          v;
    logic [63:0] mag;
    logic [63:0] q;
    v   = e;
    mag = (v < 0) ? 64'(-v) : 64'(v);
    q   = (mag << 15) / {45'd0, m};
    if (v >= 0) return (q > 64'd32767) ? DW'(32767) : DW'(q);
    if (q > 64'd32768) q = 64'd32768;
    return DW'(64'd0 - q);
  endfunction

  task automatic take_element(input logic signed [DW-1:0] e, input logic fin);
    int          v;
    int          n;
    logic [18:0] m;
    quotient_t   r;
    // Elements past the store depth are dropped, but a dropped last element
    // still closes the vector.
    if (vector_elems.size() < MAX_LEN) begin
      v = e;
      vector_elems.push_back(e);
      square_total = square_total + 37'(64'(v * v));
    end
    if (fin) begin
      m = floor_root(square_total);
      n = vector_elems.size();
      for (int k = 0; k < n; k++) begin
        r.value = (m == 0) ? '0 : scaled_quotient(vector_elems[k], m);
        r.zero  = (m == 0);
        r.last  = (k == n - 1);
        expected_quotients.push_back(r);
      end
      vector_elems.delete();
      square_total = '0;
    end
  endtask

  task automatic check_result();
    quotient_t want;
    if (expected_quotients.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, got normalized=%0d last=%0b zero=%0b",
               $time, normalized, last_result, zero_magnitude);
    end else begin
      want = expected_quotients.pop_front();
      checked++;
      if (normalized !== want.value) begin
        errors++;
        $display("%0t: normalized mismatch, expected %0d, got %0d",
                 $time, want.value, normalized);
      end
      if (last_result !== want.last) begin
        errors++;
        $display("%0t: last_result mismatch, expected %0b, got %0b",
                 $time, want.last, last_result);
      end
      if (zero_magnitude !== want.zero) begin
        errors++;
        $display("%0t: zero_magnitude mismatch, expected %0b, got %0b",
                 $time, want.zero, zero_magnitude);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      vector_elems.delete();
      expected_quotients.delete();
      square_total = '0;
    end else begin
      // Results at this edge belong to an earlier vector, so check them first.
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) take_element(element, last_element);
    end
    fail_count   <= errors;
    pending      <= expected_quotients.size();
    results_seen <= checked;
  end

endmodule

@@ test/vector_l2_normalize_tb.sv @@
// ----------------------------------------------------------------------------
// Testbench for the vector L2 normalizer
// Streams directed and random vectors into the block under random stalls on
// both channels; a checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module vector_l2_normalize_tb;

  localparam int CLK_PERIOD = 12;
  localparam int MAX_LEN    = vl2n_pkg::MAX_LENGTH_DEF;
  localparam int DW         = vl2n_pkg::DATA_W;
  // Number of random elements to stream after the directed vectors.
  localparam int RANDOM_ELEMS = 300;
  // Cycles to keep watching after the last expected result, so that a stray
  // extra transfer from the block is still caught.
  localparam int DRAIN_CYCLES = 60;

  // Element content styles for random vectors.
  typedef enum int {FILL_FULL, FILL_TINY, FILL_EXTREME, FILL_ZERO} fill_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic signed [DW-1:0] element = '0;
  logic                 last_element = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [DW-1:0] normalized;
  logic                 last_result;
  logic                 zero_magnitude;

  int fail_count;
  int pending;
  int results_seen;

  // Percent of cycles in which each side holds back.
  int send_idle_pct  = 10;
  int ready_idle_pct = 48;

  // Bookkeeping for the closing summary.
  int elems_sent   = 0;
  int vectors_sent = 0;
  int long_vectors = 0;
  int zero_vectors = 0;

  logic signed [DW-1:0] vec[$];

  always #(CLK_PERIOD / 2) clk = ~clk;

  vector_l2_normalize #(
    .MAX_LENGTH(MAX_LEN)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .element       (element),
    .last_element  (last_element),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .normalized    (normalized),
    .last_result   (last_result),
    .zero_magnitude(zero_magnitude)
  );

  vl2n_result_checker #(
    .MAX_LEN(MAX_LEN)
  ) u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .element       (element),
    .last_element  (last_element),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .normalized    (normalized),
    .last_result   (last_result),
    .zero_magnitude(zero_magnitude),
    .fail_count    (fail_count),
    .pending       (pending),
    .results_seen  (results_seen)
  );

  // The receiver decides afresh every cycle, independent of out_valid, so
  // that back-pressure lands on every phase of the emit.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= ready_idle_pct);
  end

  // One element transfer. An optional idle gap comes first; once valid is
  // raised it stays up with a steady payload until the block takes it. The
  // task returns at the accepting edge without touching in_valid, so the
  // next call makes the only assignment to it in that time step.
  task automatic send_element(input logic signed [DW-1:0] e, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    element      <= e;
    last_element <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    elems_sent++;
  endtask

  // Sends the whole of vec, flagging its final element.
  task automatic send_vector();
    for (int i = 0; i < vec.size(); i++) send_element(vec[i], i == vec.size() - 1);
    vectors_sent++;
  endtask

  function automatic logic signed [DW-1:0] pick_element(input fill_t style);
    case (style)
      FILL_TINY:    return DW'(int'($urandom_range(16)) - 8);
      FILL_EXTREME: begin
        if ($urandom_range(1) == 1) return DW'(32767 - int'($urandom_range(3)));
        return DW'(-32768 + int'($urandom_range(3)));
      end
      FILL_ZERO:    return '0;
      default:      return DW'($urandom);
    endcase
  endfunction

  initial begin
    int    random_elems;
    int    len;
    fill_t style;

    random_elems = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed vectors. A lone full-scale positive element divides by itself
    // and must saturate; the most negative element must land exactly on -1.0.
    vec = '{16'sh7fff};
    send_vector();
    vec = '{16'sh8000};
    send_vector();
    // Magnitude of one: the smallest nonzero case, both signs.
    vec = '{16'sd1};
    send_vector();
    vec = '{-16'sd1};
    send_vector();
    // All-zero vector: every result is zero with the zero_magnitude flag.
    vec = '{16'sd0, 16'sd0, 16'sd0};
    send_vector();
    zero_vectors++;
    // A 3-4-5 triangle, with truncation toward zero on both signs.
    vec = '{16'sd3, -16'sd4};
    send_vector();
    // Both extremes together, one of each sign, give a near-largest sum of squares.
    vec = '{16'sh8000, 16'sh7fff};
    send_vector();
    // Zeros mixed into a nonzero vector.
    vec = '{16'sd0, 16'sd5, 16'sd0, -16'sd5};
    send_vector();
    // Equal elements divide to exactly one half.
    vec = '{16'sd100, 16'sd100, 16'sd100, 16'sd100};
    send_vector();

    // Random vectors, mostly short. A few run past the store depth so that
    // the tail, last element included, is dropped while still closing the
    // vector. Idling changes at vector boundaries across three phases.
    while (random_elems < RANDOM_ELEMS) begin
      if (random_elems >= 2 * RANDOM_ELEMS / 3) begin
        send_idle_pct  = 0;
        ready_idle_pct = 0;
      end else if (random_elems >= RANDOM_ELEMS / 3) begin
        send_idle_pct  = 48;
        ready_idle_pct = 10;
      end
      if ($urandom_range(99) < 5 && long_vectors < 3) begin
        len = $urandom_range(MAX_LEN + 6, MAX_LEN - 1);
        if (len > MAX_LEN) long_vectors++;
      end else begin
        len = $urandom_range(12, 1);
      end
      if ($urandom_range(9) == 0) begin
        style = FILL_ZERO;
        zero_vectors++;
      end else begin
        style = fill_t'($urandom_range(2));
      end
      vec.delete();
      // A mixed vector occasionally swaps styles mid-stream.
      for (int i = 0; i < len; i++) begin
        if (style != FILL_ZERO && $urandom_range(7) == 0) vec.push_back(pick_element(FILL_FULL));
        else vec.push_back(pick_element(style));
      end
      send_vector();
      random_elems += len;
    end
    in_valid <= 1'b0;

    // Let the checker see the last transfer, wait for every expected result,
    // then watch a little longer for anything extra.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Streamed %0d elements in %0d vectors, %0d over the store depth, %0d all zero.",
             elems_sent, vectors_sent, long_vectors, zero_vectors);
    $display("Compared %0d normalized results, %0d mismatches.", results_seen, fail_count);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run, including full receiver
  // stalls on every one of the over-length vectors.
  initial begin
    #(CLK_PERIOD * 400000);
    $display("Timeout with %0d results still expected.", pending);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
